// ===== src/arp_request_responder_unit_assert.svh =====
// Assertion macros for the ARP request responder.
// Included by files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef ARP_REQUEST_RESPONDER_UNIT_ASSERT_SVH
`define ARP_REQUEST_RESPONDER_UNIT_ASSERT_SVH

// same-cycle implication
`define ARP_RR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arp responder check failed");

// next-cycle implication
`define ARP_RR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arp responder check failed");

`endif

// ===== src/arp_rr_pkg.sv =====
// Shared types, constants and byte functions of the ARP request responder.
// No dependencies.
`default_nettype none

package arp_rr_pkg;

    localparam logic [4:0]  HDR_END        = 5'd8;
    localparam logic [4:0]  SMAC_END       = 5'd14;
    localparam logic [4:0]  SIP_END        = 5'd18;
    localparam logic [4:0]  TMAC_END       = 5'd24;
    localparam logic [4:0]  PAYLOAD_LEN    = 5'd28;
    localparam logic [4:0]  LAST_IDX       = 5'd27;
    localparam logic [4:0]  COUNT_MAX      = 5'd31;

    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [15:0] OP_REQUEST     = 16'h0001;
    localparam logic [15:0] OP_REPLY       = 16'h0002;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;

    typedef enum logic [1:0] {
        CFG_OWN_IPV4 = 2'd0,
        CFG_OWN_MAC  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // expected request header, byte by byte
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = HW_TYPE_ETH[15:8];
            3'd1:    b = HW_TYPE_ETH[7:0];
            3'd2:    b = PROTO_IPV4[15:8];
            3'd3:    b = PROTO_IPV4[7:0];
            3'd4:    b = HW_ADDR_LEN;
            3'd5:    b = PROTO_ADDR_LEN;
            3'd6:    b = OP_REQUEST[15:8];
            3'd7:    b = OP_REQUEST[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_byte(
        input logic [4:0]  k,
        input logic [47:0] own_mac,
        input logic [31:0] own_ip,
        input t_job        job
    );
        logic [7:0] b;
        logic [2:0] sel;
        sel = '0;
        if (k < 5'd6) begin
            b = hdr_byte(k[2:0]);
        end else if (k == 5'd6) begin
            b = OP_REPLY[15:8];
        end else if (k == 5'd7) begin
            b = OP_REPLY[7:0];
        end else if (k < SMAC_END) begin
            sel = 3'(5'd13 - k);
            b   = 8'(own_mac >> {sel, 3'b000});
        end else if (k < SIP_END) begin
            sel = 3'(5'd17 - k);
            b   = 8'(own_ip >> {sel, 3'b000});
        end else if (k < TMAC_END) begin
            sel = 3'(5'd23 - k);
            b   = 8'(job.sender_mac >> {sel, 3'b000});
        end else begin
            sel = 3'(5'd27 - k);
            b   = 8'(job.sender_ip >> {sel, 3'b000});
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/arp_rr_front.sv =====
// Front end: parses the request one byte per item, checks the header and
// queues a reply job when a matching request ends. Uses arp_rr_pkg.
`default_nettype none

module arp_rr_front
    import arp_rr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_end,
    input  wire logic [31:0] i_own_ip,
    output logic             o_job_push,
    output t_job             o_job
);

    logic [4:0]  r_count, n_count;
    logic        r_hdr_ok, n_hdr_ok;
    logic [47:0] r_smac, n_smac;
    logic [31:0] r_sip, n_sip;
    logic [31:0] r_tip, n_tip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hdr_ok <= 1'b1;
        end else begin
            r_count  <= n_count;
            r_hdr_ok <= n_hdr_ok;
        end
        r_smac <= n_smac;
        r_sip  <= n_sip;
        r_tip  <= n_tip;
    end

    always_comb begin
        n_count    = r_count;
        n_hdr_ok   = r_hdr_ok;
        n_smac     = r_smac;
        n_sip      = r_sip;
        n_tip      = r_tip;
        o_job_push = 1'b0;
        if (i_valid) begin
            if (r_count < HDR_END) begin
                if (i_byte != hdr_byte(r_count[2:0])) begin
                    n_hdr_ok = 1'b0;
                end
            end else if (r_count < SMAC_END) begin
                n_smac = {r_smac[39:0], i_byte};
            end else if (r_count < SIP_END) begin
                n_sip = {r_sip[23:0], i_byte};
            end else if (r_count < TMAC_END) begin
                n_tip = r_tip;
            end else if (r_count < PAYLOAD_LEN) begin
                n_tip = {r_tip[23:0], i_byte};
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 5'd1;
            end
            if (i_end) begin
                o_job_push = (r_count >= LAST_IDX) && n_hdr_ok && (n_tip == i_own_ip);
                n_count    = '0;
                n_hdr_ok   = 1'b1;
            end
        end
    end

    // sender fields are complete before any byte that can end a valid request
    assign o_job.sender_mac = r_smac;
    assign o_job.sender_ip  = r_sip;

endmodule

`default_nettype wire

// ===== src/arp_rr_queue.sv =====
// Two-entry job queue between parser and reply serializer.
// Uses arp_rr_pkg.
`default_nettype none

module arp_rr_queue
    import arp_rr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output t_q_stat   o_stat
);

    t_job       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_fill == 2'd0);
    assign o_stat.full  = (r_fill == 2'd2);

endmodule

`default_nettype wire

// ===== src/arp_rr_back.sv =====
// Back end: turns one queued job into the 28 reply bytes, through an output
// register toward the consumer. Uses arp_rr_pkg.
`default_nettype none

module arp_rr_back
    import arp_rr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_head,
    input  wire logic        i_q_empty,
    output logic             o_q_pop,
    input  wire logic [47:0] i_own_mac,
    input  wire logic [31:0] i_own_ip,
    input  wire logic        i_pop,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_end
);

    logic       r_busy, n_busy;
    logic [4:0] r_k, n_k;
    t_job       r_job, n_job;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;
    logic       adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
        r_job  <= n_job;
        r_byte <= n_byte;
        r_end  <= n_end;
    end

    assign adv     = !r_valid || i_pop;
    assign o_q_pop = !i_q_empty && (!r_busy || (adv && r_k == LAST_IDX));

    always_comb begin
        n_busy  = r_busy;
        n_k     = r_k;
        n_job   = r_job;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_end   = r_end;
        if (adv) begin
            if (r_busy) begin
                n_valid = 1'b1;
                n_byte  = reply_byte(r_k, i_own_mac, i_own_ip, r_job);
                n_end   = (r_k == LAST_IDX);
                if (r_k == LAST_IDX) begin
                    n_busy = 1'b0;
                end else begin
                    n_k = r_k + 5'd1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_k    = '0;
            n_job  = i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_end   = r_end;

endmodule

`default_nettype wire

// ===== src/arp_request_responder_unit.sv =====
// Top level of the ARP request responder: config registers, parser, job queue
// and reply serializer. Uses arp_rr_pkg and arp_request_responder_unit_assert.svh.
//
// Request bytes are taken one per clock while full is low. When a request for
// own_ipv4 ends, a reply job is queued; the serializer sends its 28 bytes one per
// clock while pop is high, and a queued reply follows it with no gap. With the
// serializer idle, a job passes the queue entry, the job register and the output
// register before its first byte shows. The job queue holds two replies; full
// rises only while both entries wait, and then stalls input until the serializer
// takes a job. Write own_ipv4 and own_mac only while no reply is pending.
`default_nettype none

`include "arp_request_responder_unit_assert.svh"

module arp_request_responder_unit
    import arp_rr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_payload_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_reply_byte,
    output logic             o_reply_end
);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic        accept;
    logic        job_push;
    t_job        job_in;
    t_job        q_head;
    t_q_stat     q_stat;
    logic        q_pop;
    logic        out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_OWN_IPV4: r_own_ip  <= i_cfg_data[31:0];
                CFG_OWN_MAC:  r_own_mac <= i_cfg_data;
                default:      r_own_ip  <= r_own_ip;
            endcase
        end
    end

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    arp_rr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_byte     (i_payload_byte),
        .i_end      (i_payload_end),
        .i_own_ip   (r_own_ip),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    arp_rr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    arp_rr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_stat.empty),
        .o_q_pop   (q_pop),
        .i_own_mac (r_own_mac),
        .i_own_ip  (r_own_ip),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_byte    (o_reply_byte),
        .o_end     (o_reply_end)
    );

    assign empty = !out_valid;

    `ARP_RR_ASSERT_NOW(a_job_on_end, job_push, accept && i_payload_end)
    `ARP_RR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty)
    `ARP_RR_ASSERT_NOW(a_q_flags, q_stat.full, !q_stat.empty)

endmodule

`default_nettype wire
